/* design/range_distinct_count_window_assert.svh */
// ----------------------------------------------------------------------------
// Range distinct-count window: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RDCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdcw: same-cycle check failed");

// next-cycle implication
`define RDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdcw: next-cycle check failed");

`else

`define RDCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/rdcw_pkg.sv */
// ----------------------------------------------------------------------------
// rdcw_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rdcw_pkg;

    // port field widths
    localparam int CMD_W  = 1;
    localparam int POS_W  = 12;
    localparam int VAL_W  = 10;
    localparam int QID_W  = 16;
    localparam int DIST_W = 13;
    localparam int STAT_W = 2;

    // parameter defaults
    localparam int DEPTH_DEF         = 4096;
    localparam int VALUE_BITS_DEF    = 10;
    localparam int QUERY_ID_BITS_DEF = 16;

    // request commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_REVERSED = 2'd1;
    localparam logic [STAT_W-1:0] ST_INSIDE   = 2'd2;

    // window edge moves
    localparam logic [1:0] OP_ADD_START = 2'd0;
    localparam logic [1:0] OP_ADD_END   = 2'd1;
    localparam logic [1:0] OP_REM_START = 2'd2;
    localparam logic [1:0] OP_REM_END   = 2'd3;

    typedef struct packed {
        logic capture;     // latch the accepted request
        logic clr_wr;      // clear one histogram entry
        logic load_wr;     // write the data store for a load
        logic step_start;  // pick an edge move, read the data store
        logic hist_rd;     // read the histogram entry
        logic upd;         // write back count, move the edge
        logic out_load;    // fill the output register
    } rdcw_cmd_t;

    typedef struct packed {
        logic is_query;
        logic reversed;
        logic need_step;
        logic clr_last;
    } rdcw_sts_t;

endpackage

/* design/range_distinct_count_window.sv */
// ----------------------------------------------------------------------------
// range_distinct_count_window
// Distinct-value counter over a sliding window of a loaded array.
//
//   channel | direction | handshake           | fields
//   in      | input     | in_valid / in_stall   | command position value left
//           |           |                     | right query_id
//   out     | output    | out_valid / out_stall | answer_id distinct status
//
// A load or a refused query goes from accept through a decide state and a done state back to idle.
// A query goes through decide, then a select/read/update loop with one pass per window edge move; each move
// is a data store read, a histogram read and a histogram write-back.
// After reset the histogram is cleared one entry a cycle, with in_stall high
// until all 2**VALUE_BITS entries are clear.
// The output register lets the next request in while a result is stalled;
// that request then holds in its last cycle until the stalled result leaves.
// ----------------------------------------------------------------------------
`include "range_distinct_count_window_assert.svh"

module range_distinct_count_window
    import rdcw_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int QUERY_ID_BITS = QUERY_ID_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  value,
    input  logic [POS_W-1:0]  left,
    input  logic [POS_W-1:0]  right,
    input  logic [QID_W-1:0]  query_id,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [QID_W-1:0]  answer_id,
    output logic [DIST_W-1:0] distinct,
    output logic [STAT_W-1:0] status
);

    rdcw_cmd_t cmd;
    rdcw_sts_t sts;

    rdcw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rdcw_dp #(
        .DEPTH         (DEPTH),
        .VALUE_BITS    (VALUE_BITS),
        .QUERY_ID_BITS (QUERY_ID_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .position  (position),
        .value     (value),
        .left      (left),
        .right     (right),
        .query_id  (query_id),
        .cmd       (cmd),
        .sts       (sts),
        .answer_id (answer_id),
        .distinct  (distinct),
        .status    (status)
    );

    // one request at a time: intake closes right after an accept
    `RDCW_ASSERT_NEXT(a_single_request, clk, rst_n, in_valid && !in_stall, in_stall)
    // refused requests never carry a count
    `RDCW_ASSERT_IMPLY(a_refused_zero, clk, rst_n, out_valid && (status != ST_OK), distinct == '0)
    // histogram writes only happen while intake is closed
    `RDCW_ASSERT_IMPLY(a_hist_busy, clk, rst_n, cmd.clr_wr || cmd.upd, in_stall)
    // a filled output register is presented on the next cycle
    `RDCW_ASSERT_NEXT(a_out_fresh, clk, rst_n, cmd.out_load, out_valid)

endmodule

/* design/rdcw_ctrl.sv */
// ----------------------------------------------------------------------------
// rdcw_ctrl
// Sequencer: histogram clear after reset, request intake, edge-move loop
// and output register handshake.
// ----------------------------------------------------------------------------
module rdcw_ctrl
    import rdcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  rdcw_sts_t sts,
    output rdcw_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SEL    = 3'd3;
    localparam logic [2:0] S_RDH    = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.load_wr = !sts.is_query;
                if (sts.is_query && !sts.reversed)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SEL:
            begin
                if (sts.need_step)
                begin
                    cmd.step_start = 1'b1;
                    state_next     = S_RDH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDH:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_SEL;
            end
            S_DONE:
            begin
                // hold until the output register is free or drains now
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/rdcw_dp.sv */
// ----------------------------------------------------------------------------
// rdcw_dp
// Datapath: request registers, data store, histogram, window edges,
// distinct counter and output register.
// ----------------------------------------------------------------------------
module rdcw_dp
    import rdcw_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int QUERY_ID_BITS = QUERY_ID_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CMD_W-1:0]  command,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  value,
    input  logic [POS_W-1:0]  left,
    input  logic [POS_W-1:0]  right,
    input  logic [QID_W-1:0]  query_id,
    input  rdcw_cmd_t         cmd,
    output rdcw_sts_t         sts,
    output logic [QID_W-1:0]  answer_id,
    output logic [DIST_W-1:0] distinct,
    output logic [STAT_W-1:0] status
);

    localparam int AW         = $clog2(DEPTH);
    localparam int PTR_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = (PTR_W > POS_W) ? PTR_W : POS_W;
    localparam int NUM_VALUES = 1 << VALUE_BITS;
    localparam int QK         = (QUERY_ID_BITS < QID_W) ? QUERY_ID_BITS : QID_W;

    logic [VALUE_BITS-1:0] data_mem [DEPTH];
    logic [PTR_W-1:0]      hist_mem [NUM_VALUES];

    // captured request
    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [POS_W-1:0]      left_reg;
    logic [POS_W-1:0]      right_reg;
    logic [QK-1:0]         qid_reg;

    // window state
    logic [PTR_W-1:0]      ws_reg;
    logic [PTR_W-1:0]      ws_next;
    logic [PTR_W-1:0]      we_reg;
    logic [PTR_W-1:0]      we_next;
    logic [PTR_W-1:0]      dcnt_reg;
    logic [PTR_W-1:0]      dcnt_next;
    logic [VALUE_BITS-1:0] clr_idx_reg;

    // step pipeline
    logic [1:0]            op_reg;
    logic [1:0]            op_sel;
    logic [PTR_W-1:0]      pos_sel;
    logic [VALUE_BITS-1:0] dat_reg;
    logic [PTR_W-1:0]      hist_rd_reg;
    logic [PTR_W-1:0]      hist_new;
    logic                  op_is_add;

    // output register
    logic [QID_W-1:0]      answer_id_reg;
    logic [DIST_W-1:0]     distinct_reg;
    logic [STAT_W-1:0]     status_reg;

    logic [CMP_W-1:0]      lim_x;
    logic [CMP_W-1:0]      left_x;
    logic [CMP_W-1:0]      right_x;
    logic [CMP_W-1:0]      pos_x;
    logic [PTR_W-1:0]      left_s;
    logic [PTR_W-1:0]      new_end;
    logic                  is_query;
    logic                  reversed;
    logic                  in_win;
    logic                  in_range;
    logic                  g_start;
    logic                  g_end;
    logic                  s_start;
    logic                  s_end;

    always_comb
    begin
        lim_x    = CMP_W'(DEPTH - 1);
        left_x   = CMP_W'(left_reg);
        right_x  = CMP_W'(right_reg);
        pos_x    = CMP_W'(pos_reg);
        is_query = (cmd_reg == CMD_QUERY);
        reversed = (left_reg > right_reg);
        // saturate range ends to the last array position
        left_s   = PTR_W'((left_x > lim_x) ? lim_x : left_x);
        new_end  = PTR_W'((right_x > lim_x) ? lim_x : right_x) + PTR_W'(1);
        in_win   = (pos_x >= CMP_W'(ws_reg)) && (pos_x < CMP_W'(we_reg));
        in_range = (pos_x < CMP_W'(DEPTH));
        g_start  = (ws_reg > left_s);
        g_end    = (we_reg < new_end);
        s_start  = (ws_reg < left_s);
        s_end    = (we_reg > new_end);
    end

    // grow before shrink: start edge, end edge, then the shrinking moves
    always_comb
    begin
        if (g_start)
        begin
            op_sel  = OP_ADD_START;
            pos_sel = ws_reg - PTR_W'(1);
        end
        else if (g_end)
        begin
            op_sel  = OP_ADD_END;
            pos_sel = we_reg;
        end
        else if (s_start)
        begin
            op_sel  = OP_REM_START;
            pos_sel = ws_reg;
        end
        else
        begin
            op_sel  = OP_REM_END;
            pos_sel = we_reg - PTR_W'(1);
        end
    end

    assign sts.is_query  = is_query;
    assign sts.reversed  = reversed;
    assign sts.need_step = g_start || g_end || s_start || s_end;
    assign sts.clr_last  = (clr_idx_reg == {VALUE_BITS{1'b1}});

    assign op_is_add = (op_reg == OP_ADD_START) || (op_reg == OP_ADD_END);

    always_comb
    begin
        ws_next   = ws_reg;
        we_next   = we_reg;
        dcnt_next = dcnt_reg;
        hist_new  = hist_rd_reg;
        if (cmd.upd)
        begin
            if (op_is_add)
            begin
                hist_new = hist_rd_reg + PTR_W'(1);
                if (hist_rd_reg == '0)
                begin
                    dcnt_next = dcnt_reg + PTR_W'(1);
                end
            end
            else if (hist_rd_reg != '0)
            begin
                hist_new = hist_rd_reg - PTR_W'(1);
                if (hist_rd_reg == PTR_W'(1))
                begin
                    dcnt_next = dcnt_reg - PTR_W'(1);
                end
            end
            case (op_reg)
                OP_ADD_START: ws_next = ws_reg - PTR_W'(1);
                OP_ADD_END:   we_next = we_reg + PTR_W'(1);
                OP_REM_START: ws_next = ws_reg + PTR_W'(1);
                OP_REM_END:   we_next = we_reg - PTR_W'(1);
                default:      ws_next = ws_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= '0;
            we_reg      <= '0;
            dcnt_reg    <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            ws_reg   <= ws_next;
            we_reg   <= we_next;
            dcnt_reg <= dcnt_next;
            if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + VALUE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            pos_reg   <= position;
            val_reg   <= VALUE_BITS'(value);
            left_reg  <= left;
            right_reg <= right;
            qid_reg   <= QK'(query_id);
        end
        if (cmd.step_start)
        begin
            op_reg <= op_sel;
        end
        if (cmd.out_load)
        begin
            answer_id_reg <= QID_W'(qid_reg);
            distinct_reg  <= (is_query && !reversed) ? DIST_W'(dcnt_reg) : '0;
            if (is_query)
            begin
                status_reg <= reversed ? ST_REVERSED : ST_OK;
            end
            else
            begin
                status_reg <= in_win ? ST_INSIDE : ST_OK;
            end
        end
    end

    // data store: one write port for loads, one registered read for steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && !in_win && in_range)
        begin
            data_mem[pos_x[AW-1:0]] <= val_reg;
        end
        if (cmd.step_start)
        begin
            dat_reg <= data_mem[pos_sel[AW-1:0]];
        end
    end

    // histogram: clearing pass or count write-back, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            hist_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.upd)
        begin
            hist_mem[dat_reg] <= hist_new;
        end
        if (cmd.hist_rd)
        begin
            hist_rd_reg <= hist_mem[dat_reg];
        end
    end

    assign answer_id = answer_id_reg;
    assign distinct  = distinct_reg;
    assign status    = status_reg;

endmodule
